@@ rtl/rec_pkg.sv @@
// ----------------------------------------------------------------------------
// rec_pkg
// Widths, register codes and shared types of the rotated ellipsoid test.
// ----------------------------------------------------------------------------
package rec_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int TRIG_WIDTH     = 16;
	localparam int SCALE_WIDTH    = 32;
	localparam int REG_WIDTH      = 32;
	localparam int NUM_LANES      = 8;
	localparam int NUM_AXES       = 3;
	localparam int LANE_LAT       = 10;

	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = DW + TRIG_WIDTH;
	localparam int UW  = PW + 1;
	localparam int RW  = UW + TRIG_WIDTH;
	localparam int ZW  = PW + TRIG_FRAC_BITS;
	localparam int YW  = UW + TRIG_FRAC_BITS;
	localparam int NW0 = (RW > ZW) ? RW : ZW;
	localparam int NW  = ((NW0 > YW) ? NW0 : YW) + 1;
	localparam int HW  = (NW + 1) / 2;
	localparam int MW  = 2 * HW;
	localparam int SQW = 2 * MW;
	localparam int QW  = HW + SCALE_WIDTH;
	localparam int WW  = SQW + SCALE_WIDTH;
	localparam int SW  = WW + 2;
	localparam int THR = 48 + 4 * TRIG_FRAC_BITS;

	localparam int IDX_WIDTH = 8;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_CENTER_X     = 8'd0,
		REG_CENTER_Y     = 8'd1,
		REG_CENTER_Z     = 8'd2,
		REG_AZIMUTH_TRIG = 8'd3,
		REG_POLAR_TRIG   = 8'd4,
		REG_SCALE_X      = 8'd5,
		REG_SCALE_Y      = 8'd6,
		REG_SCALE_Z      = 8'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] center_x;
		logic [COORD_WIDTH-1:0] center_y;
		logic [COORD_WIDTH-1:0] center_z;
		logic [REG_WIDTH-1:0]   azimuth_trig;
		logic [REG_WIDTH-1:0]   polar_trig;
		logic [SCALE_WIDTH-1:0] scale_x;
		logic [SCALE_WIDTH-1:0] scale_y;
		logic [SCALE_WIDTH-1:0] scale_z;
	} cfg_t;

endpackage

@@ rtl/rec_lane.sv @@
// ----------------------------------------------------------------------------
// rec_lane
// Pipelined containment test of one point against the rotated ellipsoid.
// ----------------------------------------------------------------------------
module rec_lane
	import rec_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  cfg_t                   cfg,
	input  logic [COORD_WIDTH-1:0] px,
	input  logic [COORD_WIDTH-1:0] py,
	input  logic [COORD_WIDTH-1:0] pz,
	output logic                   hit
);

	logic signed [TRIG_WIDTH-1:0] ca, sa, cp, sp;
	assign ca = signed'(cfg.azimuth_trig[TRIG_WIDTH-1:0]);
	assign sa = signed'(cfg.azimuth_trig[2*TRIG_WIDTH-1:TRIG_WIDTH]);
	assign cp = signed'(cfg.polar_trig[TRIG_WIDTH-1:0]);
	assign sp = signed'(cfg.polar_trig[2*TRIG_WIDTH-1:TRIG_WIDTH]);

	logic [SCALE_WIDTH-1:0] scale [NUM_AXES];
	assign scale[0] = cfg.scale_x;
	assign scale[1] = cfg.scale_y;
	assign scale[2] = cfg.scale_z;

	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0] dxca_s2, dysa_s2, dxsa_s2, dyca_s2, dzsp_s2, dzcp_s2;
	logic signed [UW-1:0] u_s3, ny_s3;
	logic signed [PW-1:0] dzsp_s3, dzcp_s3;
	logic signed [RW-1:0] ucp_s4, usp_s4;
	logic signed [UW-1:0] ny_s4;
	logic signed [PW-1:0] dzsp_s4, dzcp_s4;
	logic signed [NW-1:0] n_c [NUM_AXES];
	logic [MW-1:0]        mag_s5 [NUM_AXES];
	logic [MW-1:0]        hh_s6 [NUM_AXES];
	logic [MW-1:0]        hl_s6 [NUM_AXES];
	logic [MW-1:0]        ll_s6 [NUM_AXES];
	logic [SQW-1:0]       sq_s7 [NUM_AXES];
	logic [QW-1:0]        q_s8 [NUM_AXES][4];
	logic [WW-1:0]        w_s9 [NUM_AXES];
	logic [SW-1:0]        sum_c;
	logic                 inside_s10;

	assign n_c[0] = NW'(ucp_s4) - (NW'(dzsp_s4) <<< TRIG_FRAC_BITS);
	assign n_c[1] = NW'(ny_s4) <<< TRIG_FRAC_BITS;
	assign n_c[2] = NW'(usp_s4) + (NW'(dzcp_s4) <<< TRIG_FRAC_BITS);
	assign sum_c  = SW'(w_s9[0]) + SW'(w_s9[1]) + SW'(w_s9[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DW'(signed'(px)) - DW'(signed'(cfg.center_x));
			dy_s1   <= DW'(signed'(py)) - DW'(signed'(cfg.center_y));
			dz_s1   <= DW'(signed'(pz)) - DW'(signed'(cfg.center_z));
			dxca_s2 <= PW'(dx_s1) * PW'(ca);
			dysa_s2 <= PW'(dy_s1) * PW'(sa);
			dxsa_s2 <= PW'(dx_s1) * PW'(sa);
			dyca_s2 <= PW'(dy_s1) * PW'(ca);
			dzsp_s2 <= PW'(dz_s1) * PW'(sp);
			dzcp_s2 <= PW'(dz_s1) * PW'(cp);
			u_s3    <= UW'(dxca_s2) + UW'(dysa_s2);
			ny_s3   <= UW'(dxsa_s2) - UW'(dyca_s2);
			dzsp_s3 <= dzsp_s2;
			dzcp_s3 <= dzcp_s2;
			ucp_s4  <= RW'(u_s3) * RW'(cp);
			usp_s4  <= RW'(u_s3) * RW'(sp);
			ny_s4   <= ny_s3;
			dzsp_s4 <= dzsp_s3;
			dzcp_s4 <= dzcp_s3;
			for (int a = 0; a < NUM_AXES; a++) begin
				mag_s5[a] <= MW'(unsigned'(n_c[a][NW-1] ? -n_c[a] : n_c[a]));
				hh_s6[a]  <= MW'(mag_s5[a][MW-1:HW]) * MW'(mag_s5[a][MW-1:HW]);
				hl_s6[a]  <= MW'(mag_s5[a][MW-1:HW]) * MW'(mag_s5[a][HW-1:0]);
				ll_s6[a]  <= MW'(mag_s5[a][HW-1:0]) * MW'(mag_s5[a][HW-1:0]);
				sq_s7[a]  <= (SQW'(hh_s6[a]) << MW) + (SQW'(hl_s6[a]) << (HW + 1))
					+ SQW'(ll_s6[a]);
				for (int k = 0; k < 4; k++)
					q_s8[a][k] <= QW'(sq_s7[a][k*HW +: HW]) * QW'(scale[a]);
				w_s9[a] <= WW'(q_s8[a][0]) + (WW'(q_s8[a][1]) << HW)
					+ (WW'(q_s8[a][2]) << (2 * HW)) + (WW'(q_s8[a][3]) << (3 * HW));
			end
			inside_s10 <= (sum_c <= (SW'(1) << THR));
		end
	end

	assign hit = inside_s10;

endmodule

@@ rtl/rec_merge.sv @@
// ----------------------------------------------------------------------------
// rec_merge
// Combines the lane verdicts and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module rec_merge
	import rec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic                 box,
	input  logic [NUM_LANES-1:0] lane_inside,
	output logic                 out_valid,
	output logic                 is_inside
);

	logic vld_q, inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_q <= box ? &lane_inside : lane_inside[0];
		end
	end

	assign out_valid = vld_q;
	assign is_inside = inside_q;

endmodule

@@ rtl/rotated_ellipsoid_containment.sv @@
// ----------------------------------------------------------------------------
// rotated_ellipsoid_containment
// Point or box containment test against a rotated, offset ellipsoid.
//
// Input channel (in_valid/in_ready) carries a command and two corners; the
// output channel (out_valid/out_ready) returns one is_inside bit per item.
// Eight lanes test the eight box corners side by side; a point test uses
// lane zero. Each lane is a ten stage pipeline, and a merge register follows
// it to hold the result. One item is taken every cycle while the receiver
// keeps out_ready high.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops until the result transfers.
// Registers are written through write_enable/write_index/write_data. The user
// must write them only while the block is idle; the block does not enforce it.
// Reset clears the valid pipeline and loads center 0, unit trig, unit scales.
// ----------------------------------------------------------------------------
module rotated_ellipsoid_containment
	import rec_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   write_enable,
	input  logic [IDX_WIDTH-1:0]   write_index,
	input  logic [REG_WIDTH-1:0]   write_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic [COORD_WIDTH-1:0] low_x,
	input  logic [COORD_WIDTH-1:0] low_y,
	input  logic [COORD_WIDTH-1:0] low_z,
	input  logic [COORD_WIDTH-1:0] high_x,
	input  logic [COORD_WIDTH-1:0] high_y,
	input  logic [COORD_WIDTH-1:0] high_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   is_inside
);

	cfg_t                 cfg_q;
	logic                 en;
	logic [LANE_LAT-1:0]  vld_pipe_q;
	logic [LANE_LAT-1:0]  cmd_pipe_q;
	logic [NUM_LANES-1:0] lane_inside;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
			cfg_q.center_z     <= '0;
			cfg_q.azimuth_trig <= REG_WIDTH'(1) << TRIG_FRAC_BITS;
			cfg_q.polar_trig   <= REG_WIDTH'(1) << TRIG_FRAC_BITS;
			cfg_q.scale_x      <= SCALE_WIDTH'(1) << 16;
			cfg_q.scale_y      <= SCALE_WIDTH'(1) << 16;
			cfg_q.scale_z      <= SCALE_WIDTH'(1) << 16;
		end else if (write_enable) begin
			unique case (write_index)
				REG_CENTER_X:     cfg_q.center_x     <= write_data;
				REG_CENTER_Y:     cfg_q.center_y     <= write_data;
				REG_CENTER_Z:     cfg_q.center_z     <= write_data;
				REG_AZIMUTH_TRIG: cfg_q.azimuth_trig <= write_data;
				REG_POLAR_TRIG:   cfg_q.polar_trig   <= write_data;
				REG_SCALE_X:      cfg_q.scale_x      <= write_data;
				REG_SCALE_Y:      cfg_q.scale_y      <= write_data;
				REG_SCALE_Z:      cfg_q.scale_z      <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pipe_q <= '0;
		end else if (en) begin
			vld_pipe_q <= {vld_pipe_q[LANE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_pipe_q <= {cmd_pipe_q[LANE_LAT-2:0], command};
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rec_lane u_lane (
			.clk (clk),
			.en  (en),
			.cfg (cfg_q),
			.px  ((i & 1) != 0 ? high_x : low_x),
			.py  ((i & 2) != 0 ? high_y : low_y),
			.pz  ((i & 4) != 0 ? high_z : low_z),
			.hit (lane_inside[i])
		);
	end

	rec_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.vld         (vld_pipe_q[LANE_LAT-1]),
		.box         (cmd_pipe_q[LANE_LAT-1]),
		.lane_inside (lane_inside),
		.out_valid   (out_valid),
		.is_inside   (is_inside)
	);

endmodule
